FILE: design/rbst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared widths, constants and types of the ray versus box slab test.
// ----------------------------------------------------------------------------
package rbst_pkg;

    localparam int Q_W     = 32;
    localparam int DIFF_W  = Q_W + 1;
    localparam int FRAC_W  = 16;
    localparam int NUM_W   = DIFF_W + FRAC_W;
    localparam int QBIT_N  = Q_W - 1;
    localparam int DIV_LAT = QBIT_N + 2;
    localparam int AXIS_N  = 3;
    localparam int ADDR_W  = 5;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_LOW_X  = 3'd0,
        REG_LOW_Y  = 3'd1,
        REG_LOW_Z  = 3'd2,
        REG_HIGH_X = 3'd3,
        REG_HIGH_Y = 3'd4,
        REG_HIGH_Z = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic zero;
        logic in_slab;
    } axis_flag_t;

endpackage
`default_nettype wire

FILE: design/rbst_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_div
// Pipelined restoring divider, one quotient bit per stage, saturated signed
// Q16.16 result truncated toward zero.
// ----------------------------------------------------------------------------
module rbst_div (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [rbst_pkg::NUM_W-1:0]      num_mag,
    input  wire logic [rbst_pkg::Q_W-1:0]        den_mag,
    input  wire logic                            neg,
    output logic signed [rbst_pkg::Q_W-1:0]      quo
);
    import rbst_pkg::*;

    logic [NUM_W-1:0]  rem_reg [0:QBIT_N];
    logic [QBIT_N-1:0] q_reg   [0:QBIT_N];
    logic [Q_W-1:0]    den_reg [0:QBIT_N];
    logic              neg_reg [0:QBIT_N];
    logic              ovf_reg [0:QBIT_N];
    logic signed [Q_W-1:0] quo_reg;
    logic signed [Q_W-1:0] quo_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num_mag;
            q_reg[0]   <= '0;
            den_reg[0] <= den_mag;
            neg_reg[0] <= neg;
            ovf_reg[0] <= {{(64-NUM_W){1'b0}}, num_mag} >=
                          {1'b0, den_mag, {QBIT_N{1'b0}}};
        end
    end

    for (genvar k = 1; k <= QBIT_N; k++)
    begin : g_stage
        localparam int B = QBIT_N - k;
        logic [63:0]       trial;
        logic              ge;
        logic [NUM_W-1:0]  rem_next;
        logic [QBIT_N-1:0] q_next;

        always_comb
        begin
            trial    = {{(64-Q_W){1'b0}}, den_reg[k-1]} << B;
            ge       = {{(64-NUM_W){1'b0}}, rem_reg[k-1]} >= trial;
            rem_next = ge ? rem_reg[k-1] - trial[NUM_W-1:0] : rem_reg[k-1];
            q_next   = q_reg[k-1];
            q_next[B] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                q_reg[k]   <= q_next;
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    always_comb
    begin
        if (ovf_reg[QBIT_N])
            quo_next = neg_reg[QBIT_N] ? Q_MIN : Q_MAX;
        else if (neg_reg[QBIT_N])
            quo_next = -$signed({1'b0, q_reg[QBIT_N]});
        else
            quo_next = $signed({1'b0, q_reg[QBIT_N]});
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule
`default_nettype wire

FILE: design/rbst_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_merge
// Orders each axis pair and narrows the interval over x, y and z in three
// register stages; the last stage is the output word register.
// ----------------------------------------------------------------------------
module rbst_merge (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire rbst_pkg::axis_flag_t              flag [0:rbst_pkg::AXIS_N-1],
    input  wire logic signed [rbst_pkg::Q_W-1:0]   t_a  [0:rbst_pkg::AXIS_N-1],
    input  wire logic signed [rbst_pkg::Q_W-1:0]   t_b  [0:rbst_pkg::AXIS_N-1],
    output logic                                   out_valid,
    output logic                                   hit,
    output logic signed [rbst_pkg::Q_W-1:0]        t_enter,
    output logic signed [rbst_pkg::Q_W-1:0]        t_exit
);
    import rbst_pkg::*;

    logic                  v1_reg, v2_reg, v3_reg;
    logic signed [Q_W-1:0] lo1_reg [0:AXIS_N-1];
    logic signed [Q_W-1:0] hi1_reg [0:AXIS_N-1];
    logic                  miss1_reg;
    logic signed [Q_W-1:0] lo_z2_reg, hi_z2_reg, ent2_reg, lev2_reg;
    logic                  miss2_reg;
    logic                  hit3_reg;
    logic signed [Q_W-1:0] ent3_reg, lev3_reg;

    logic signed [Q_W-1:0] lo1_next [0:AXIS_N-1];
    logic signed [Q_W-1:0] hi1_next [0:AXIS_N-1];
    logic                  miss1_next;
    logic signed [Q_W-1:0] ent2_next, lev2_next;
    logic                  miss2_next;
    logic                  hit3_next;
    logic signed [Q_W-1:0] ent3_next, lev3_next;

    always_comb
    begin
        miss1_next = 1'b0;
        for (int a = 0; a < AXIS_N; a++)
        begin
            if (flag[a].zero)
            begin
                lo1_next[a] = Q_MIN;
                hi1_next[a] = Q_MAX;
                if (!flag[a].in_slab)
                    miss1_next = 1'b1;
            end
            else if (t_a[a] > t_b[a])
            begin
                lo1_next[a] = t_b[a];
                hi1_next[a] = t_a[a];
            end
            else
            begin
                lo1_next[a] = t_a[a];
                hi1_next[a] = t_b[a];
            end
        end
    end

    always_comb
    begin
        miss2_next = miss1_reg || (lo1_reg[0] > hi1_reg[1]) || (lo1_reg[1] > hi1_reg[0]);
        ent2_next  = (lo1_reg[1] > lo1_reg[0]) ? lo1_reg[1] : lo1_reg[0];
        lev2_next  = (hi1_reg[1] < hi1_reg[0]) ? hi1_reg[1] : hi1_reg[0];
    end

    always_comb
    begin
        ent3_next = (lo_z2_reg > ent2_reg) ? lo_z2_reg : ent2_reg;
        lev3_next = (hi_z2_reg < lev2_reg) ? hi_z2_reg : lev2_reg;
        hit3_next = !miss2_reg && !(ent2_reg > hi_z2_reg) && !(lo_z2_reg > lev2_reg) &&
                    !lev3_next[Q_W-1];
        if (!hit3_next)
        begin
            ent3_next = '0;
            lev3_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo1_reg   <= lo1_next;
            hi1_reg   <= hi1_next;
            miss1_reg <= miss1_next;
            lo_z2_reg <= lo1_reg[2];
            hi_z2_reg <= hi1_reg[2];
            ent2_reg  <= ent2_next;
            lev2_reg  <= lev2_next;
            miss2_reg <= miss2_next;
            hit3_reg  <= hit3_next;
            ent3_reg  <= ent3_next;
            lev3_reg  <= lev3_next;
        end
    end

    assign out_valid = v3_reg;
    assign hit       = hit3_reg;
    assign t_enter   = ent3_reg;
    assign t_exit    = lev3_reg;

endmodule
`default_nettype wire

FILE: design/ray_box_slab_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Ray against axis-aligned box slab test, streaming, six box registers.
// ----------------------------------------------------------------------------
// Throughput: one ray per cycle while the output word is not stalled;
// the 31-stage bit-per-stage divider sets depth.
// The pipeline advances as a whole whenever the output word is empty or taken.
// Reset clears all valid bits and the six box registers to zero.
// ----------------------------------------------------------------------------
module ray_box_slab_test (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rbst_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
    input  wire logic [191:0]                 s_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // hit (1), t_enter (32), t_exit (32), zero fill (7)
    output logic [71:0]                       m_tdata
);
    import rbst_pkg::*;

    logic signed [Q_W-1:0] box_low_reg  [0:AXIS_N-1];
    logic signed [Q_W-1:0] box_high_reg [0:AXIS_N-1];
    logic                  wr_en;
    reg_idx_t              wr_idx;

    logic                     adv;
    logic                     v1_reg, v2_reg;
    logic signed [DIFF_W-1:0] dlo1_reg [0:AXIS_N-1];
    logic signed [DIFF_W-1:0] dhi1_reg [0:AXIS_N-1];
    logic signed [Q_W-1:0]    dir1_reg [0:AXIS_N-1];
    axis_flag_t               flg1_reg [0:AXIS_N-1];
    axis_flag_t               flg2_reg [0:AXIS_N-1];
    logic [NUM_W-1:0]         nlo2_reg [0:AXIS_N-1];
    logic [NUM_W-1:0]         nhi2_reg [0:AXIS_N-1];
    logic [Q_W-1:0]           den2_reg [0:AXIS_N-1];
    logic                     neglo2_reg [0:AXIS_N-1];
    logic                     neghi2_reg [0:AXIS_N-1];
    logic                     dv_reg  [0:DIV_LAT-1];
    axis_flag_t               dfl_reg [0:DIV_LAT-1][0:AXIS_N-1];

    logic signed [Q_W-1:0] org      [0:AXIS_N-1];
    logic signed [Q_W-1:0] dir      [0:AXIS_N-1];
    logic signed [Q_W-1:0] t_a      [0:AXIS_N-1];
    logic signed [Q_W-1:0] t_b      [0:AXIS_N-1];
    logic [DIFF_W-1:0]     alo      [0:AXIS_N-1];
    logic [DIFF_W-1:0]     ahi      [0:AXIS_N-1];

    logic                  hit;
    logic signed [Q_W-1:0] t_enter, t_exit;

    // configuration port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXIS_N; a++)
            begin
                box_low_reg[a]  <= '0;
                box_high_reg[a] <= '0;
            end
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_LOW_X:  box_low_reg[0]  <= pwdata;
                REG_LOW_Y:  box_low_reg[1]  <= pwdata;
                REG_LOW_Z:  box_low_reg[2]  <= pwdata;
                REG_HIGH_X: box_high_reg[0] <= pwdata;
                REG_HIGH_Y: box_high_reg[1] <= pwdata;
                REG_HIGH_Z: box_high_reg[2] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (wr_idx)
            REG_LOW_X:  prdata = box_low_reg[0];
            REG_LOW_Y:  prdata = box_low_reg[1];
            REG_LOW_Z:  prdata = box_low_reg[2];
            REG_HIGH_X: prdata = box_high_reg[0];
            REG_HIGH_Y: prdata = box_high_reg[1];
            REG_HIGH_Z: prdata = box_high_reg[2];
            default:    prdata = '0;
        endcase
    end

    // stream control
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_comb
    begin
        for (int a = 0; a < AXIS_N; a++)
        begin
            org[a] = s_tdata[a*Q_W +: Q_W];
            dir[a] = s_tdata[(a+AXIS_N)*Q_W +: Q_W];
            alo[a] = dlo1_reg[a][DIFF_W-1] ? DIFF_W'(-dlo1_reg[a]) : dlo1_reg[a];
            ahi[a] = dhi1_reg[a][DIFF_W-1] ? DIFF_W'(-dhi1_reg[a]) : dhi1_reg[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++)
                dv_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            dv_reg[0] <= v2_reg;
            for (int i = 1; i < DIV_LAT; i++)
                dv_reg[i] <= dv_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < AXIS_N; a++)
            begin
                dlo1_reg[a] <= {box_low_reg[a][Q_W-1], box_low_reg[a]} -
                               {org[a][Q_W-1], org[a]};
                dhi1_reg[a] <= {box_high_reg[a][Q_W-1], box_high_reg[a]} -
                               {org[a][Q_W-1], org[a]};
                dir1_reg[a] <= dir[a];
                flg1_reg[a].zero    <= (dir[a] == '0);
                flg1_reg[a].in_slab <= (org[a] >= box_low_reg[a]) &&
                                       (org[a] <= box_high_reg[a]);
                nlo2_reg[a]   <= {alo[a], {FRAC_W{1'b0}}};
                nhi2_reg[a]   <= {ahi[a], {FRAC_W{1'b0}}};
                den2_reg[a]   <= dir1_reg[a][Q_W-1] ? Q_W'(-dir1_reg[a]) : dir1_reg[a];
                neglo2_reg[a] <= dlo1_reg[a][DIFF_W-1] ^ dir1_reg[a][Q_W-1];
                neghi2_reg[a] <= dhi1_reg[a][DIFF_W-1] ^ dir1_reg[a][Q_W-1];
                flg2_reg[a]   <= flg1_reg[a];
                dfl_reg[0][a] <= flg2_reg[a];
                for (int i = 1; i < DIV_LAT; i++)
                    dfl_reg[i][a] <= dfl_reg[i-1][a];
            end
        end
    end

    for (genvar a = 0; a < AXIS_N; a++)
    begin : g_axis
        rbst_div u_div_lo (
            .clk     (clk),
            .en      (adv),
            .num_mag (nlo2_reg[a]),
            .den_mag (den2_reg[a]),
            .neg     (neglo2_reg[a]),
            .quo     (t_a[a])
        );
        rbst_div u_div_hi (
            .clk     (clk),
            .en      (adv),
            .num_mag (nhi2_reg[a]),
            .den_mag (den2_reg[a]),
            .neg     (neghi2_reg[a]),
            .quo     (t_b[a])
        );
    end

    rbst_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (dv_reg[DIV_LAT-1]),
        .flag      (dfl_reg[DIV_LAT-1]),
        .t_a       (t_a),
        .t_b       (t_b),
        .out_valid (m_tvalid),
        .hit       (hit),
        .t_enter   (t_enter),
        .t_exit    (t_exit)
    );

    assign m_tdata = {7'd0, t_exit, t_enter, hit};

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[64:1] == '0)
        else $error("miss word carries nonzero distances");

    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |->
            $signed(m_tdata[32:1]) <= $signed(m_tdata[64:33]) && !m_tdata[64])
        else $error("hit word with inverted or negative interval");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

endmodule
`default_nettype wire
